@@ sv/fft_pkg.sv @@
// ----------------------------------------------------------------------------
// FFT package
// Shared constants, types and twiddle table for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package fft_pkg;

  localparam int LOG2_MAX_POINTS_DEF = 6;
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int ACC_W               = 22;
  localparam int TW_W                = 16;
  localparam int CFG_W               = 3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_WR,
    ST_EMIT
  } fft_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_wr;    // write sample into store
    logic rd_a;       // read a operand
    logic rd_b;       // read b operand
    logic mul;        // register products
    logic wr_a;       // write sum
    logic wr_b;       // write difference
    logic emit_rd;    // read bin for output
  } fft_cmd_t;

  // quarter-wave cosine, j = 0..16
  function automatic logic signed [16:0] qcos(input logic [4:0] j);
    case (j)
      5'd0:  qcos = 17'sd32768; 5'd1:  qcos = 17'sd32610;
      5'd2:  qcos = 17'sd32138; 5'd3:  qcos = 17'sd31357;
      5'd4:  qcos = 17'sd30274; 5'd5:  qcos = 17'sd28899;
      5'd6:  qcos = 17'sd27246; 5'd7:  qcos = 17'sd25330;
      5'd8:  qcos = 17'sd23170; 5'd9:  qcos = 17'sd20788;
      5'd10: qcos = 17'sd18205; 5'd11: qcos = 17'sd15447;
      5'd12: qcos = 17'sd12540; 5'd13: qcos = 17'sd9512;
      5'd14: qcos = 17'sd6393;  5'd15: qcos = 17'sd3212;
      default: qcos = 17'sd0;
    endcase
  endfunction

  function automatic logic signed [TW_W-1:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) sat16 = 16'sh7fff;
    else if (v < -17'sd32768) sat16 = 16'sh8000;
    else sat16 = v[TW_W-1:0];
  endfunction

  // twiddle k of 64-point table, k in 0..31
  function automatic logic [2*TW_W-1:0] twiddle(input logic [4:0] k);
    logic signed [16:0] c;
    logic signed [16:0] s;
    if (k <= 5'd16) begin
      c = qcos(k);
      s = qcos(5'd16 - k);
    end else begin
      c = -qcos(5'd0 - k);
      s = qcos(k - 5'd16);
    end
    twiddle = {sat16(c), sat16(-s)};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
    if (v > $signed({{3{1'b0}}, {(ACC_W-1){1'b1}}})) sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    else if (v < $signed({{3{1'b1}}, {(ACC_W-1){1'b0}}})) sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    else sat_acc = v[ACC_W-1:0];
  endfunction

endpackage

@@ sv/fft_ctrl.sv @@
// ----------------------------------------------------------------------------
// FFT controller
// Sequences sample loading, butterfly stages and bin emission.
// ----------------------------------------------------------------------------
module fft_ctrl import fft_pkg::*; #(
  parameter int LOG2_MAX_POINTS = LOG2_MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CFG_W-1:0]           points_log2,
  input  logic                       cfg_wr,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_last,
  output fft_cmd_t                   cmd,
  output logic [LOG2_MAX_POINTS-1:0] addr_a,
  output logic [LOG2_MAX_POINTS-1:0] addr_b,
  output logic [4:0]                 tw_idx
);

  localparam int LW = $clog2(LOG2_MAX_POINTS + 1);
  localparam int AW = LOG2_MAX_POINTS;

  fft_state_t           state, state_next;
  logic [AW:0]          fill_count;
  logic [LW-1:0]        stage;      // 1..l
  logic [AW-1:0]        bfly;       // butterfly counter within stage
  logic [AW:0]          emit_cnt;
  logic                 obuf_full;  // emitted bin waiting in datapath
  logic [LW-1:0]        eff_l;
  logic [AW:0]          npts;
  logic                 in_acc;
  logic                 out_acc;
  logic [AW-1:0]        half_mask;
  logic [AW-1:0]        kk;
  logic [AW-1:0]        base;
  logic [AW-1:0]        rev;
  logic                 emit_fire;

  // effective transform length
  always_comb begin
    if (points_log2 == '0) eff_l = LW'(1);
    else if (32'(points_log2) > LOG2_MAX_POINTS) eff_l = LW'(LOG2_MAX_POINTS);
    else eff_l = LW'(points_log2);
    npts = (AW+1)'(1) << eff_l;
  end

  // bit-reversed load address
  always_comb begin
    rev = '0;
    for (int i = 0; i < AW; i++) begin
      if (i < 32'(eff_l)) rev[32'(eff_l) - 1 - i] = fill_count[i];
    end
  end

  // butterfly addresses: k = low stage-1 bits, base = remaining bits shifted up
  always_comb begin
    half_mask = (AW'(1) << (stage - LW'(1))) - AW'(1);
    kk        = bfly & half_mask;
    base      = (bfly & ~half_mask) << 1;
    tw_idx    = 5'((32'(kk) << (6 - 32'(stage))) & 31);
  end

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state != ST_LOAD);
  assign out_valid = obuf_full;
  assign emit_fire = (state == ST_EMIT) && (emit_cnt < npts) && (!obuf_full || out_acc);

  always_comb begin
    state_next = state;
    cmd        = '0;
    addr_a     = '0;
    addr_b     = '0;
    case (state)
      ST_LOAD: begin
        addr_a      = rev;
        cmd.load_wr = in_acc;
        if (in_acc && (fill_count + 1'b1 == npts)) state_next = ST_RD_A;
      end
      ST_RD_A: begin
        addr_a   = base | kk;
        cmd.rd_a = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        addr_b   = (base | kk) | (AW'(1) << (stage - LW'(1)));
        cmd.rd_b = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        addr_a   = base | kk;
        addr_b   = (base | kk) | (AW'(1) << (stage - LW'(1)));
        cmd.wr_a = 1'b1;
        cmd.wr_b = 1'b1;
        if ((AW+1)'(bfly) + 1'b1 == (npts >> 1)) begin
          if (stage == eff_l) state_next = ST_EMIT;
          else state_next = ST_RD_A;
        end else begin
          state_next = ST_RD_A;
        end
      end
      ST_EMIT: begin
        addr_a      = emit_cnt[AW-1:0];
        cmd.emit_rd = emit_fire;
        if (emit_cnt == npts && (!obuf_full || out_acc)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      stage      <= LW'(1);
      bfly       <= '0;
      emit_cnt   <= '0;
      obuf_full  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      if (cfg_wr) fill_count <= '0;
      else if (cmd.load_wr) begin
        if (fill_count + 1'b1 == npts) fill_count <= '0;
        else fill_count <= fill_count + 1'b1;
      end
      if (state == ST_LOAD) begin
        stage    <= LW'(1);
        bfly     <= '0;
        emit_cnt <= '0;
      end
      if (state == ST_WR) begin
        if ((AW+1)'(bfly) + 1'b1 == (npts >> 1)) begin
          bfly  <= '0;
          stage <= stage + LW'(1);
        end else begin
          bfly <= bfly + 1'b1;
        end
      end
      if (emit_fire) begin
        emit_cnt  <= emit_cnt + 1'b1;
        obuf_full <= 1'b1;
        out_last  <= (emit_cnt + 1'b1 == npts);
      end else if (out_acc) begin
        obuf_full <= 1'b0;
      end
    end
  end

  // assertions
  a_no_in_outside_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> state == ST_LOAD) else $error("load outside load state");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= npts) else $error("emit count overrun");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_last) |-> emit_cnt == npts) else $error("last bin mismatch");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < npts || state != ST_LOAD) else $error("fill count overrun");

endmodule

@@ sv/fft_dp.sv @@
// ----------------------------------------------------------------------------
// FFT datapath
// Work store, complex multiply, saturating butterfly and output register.
// ----------------------------------------------------------------------------
module fft_dp import fft_pkg::*; #(
  parameter int LOG2_MAX_POINTS = LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  fft_cmd_t                       cmd,
  input  logic [LOG2_MAX_POINTS-1:0]     addr_a,
  input  logic [LOG2_MAX_POINTS-1:0]     addr_b,
  input  logic [4:0]                     tw_idx,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [ACC_W-1:0]        bin_real,
  output logic signed [ACC_W-1:0]        bin_imag
);

  localparam int DEPTH = 1 << LOG2_MAX_POINTS;
  localparam int PW    = ACC_W + TW_W;

  logic [2*ACC_W-1:0]       mem [DEPTH];
  logic [2*ACC_W-1:0]       rd_q;
  logic signed [ACC_W-1:0]  a_re, a_im, b_re, b_im;
  logic signed [TW_W-1:0]   w_re, w_im;
  logic signed [PW-1:0]     p_rr, p_ii, p_ri, p_ir;
  logic signed [PW+1:0]     t_re, t_im;
  logic signed [ACC_W+1:0]  h_re, h_im;
  logic signed [ACC_W-1:0]  s_in;
  logic [2*TW_W-1:0]        tw;

  // sample saturated to store width
  always_comb begin
    if (SAMPLE_WIDTH > ACC_W) begin
      if ($signed(sample) > $signed({1'b0, {(ACC_W-1){1'b1}}})) s_in = {1'b0, {(ACC_W-1){1'b1}}};
      else if ($signed(sample) < $signed({1'b1, {(ACC_W-1){1'b0}}})) s_in = {1'b1, {(ACC_W-1){1'b0}}};
      else s_in = ACC_W'(sample);
    end else begin
      s_in = ACC_W'(sample);
    end
  end

  assign tw = twiddle(tw_idx);

  // b operand sits in the read register during the multiply cycle
  assign b_re = rd_q[2*ACC_W-1:ACC_W];
  assign b_im = rd_q[ACC_W-1:0];

  // store read
  always_ff @(posedge clk) begin
    if (cmd.rd_a || cmd.emit_rd) rd_q <= mem[addr_a];
    else if (cmd.rd_b) rd_q <= mem[addr_b];
  end

  // store writes: one port per cycle except butterfly write pair
  always_ff @(posedge clk) begin
    if (cmd.load_wr) mem[addr_a] <= {s_in, {ACC_W{1'b0}}};
    if (cmd.wr_a) mem[addr_a] <= {sat_acc((ACC_W+2)'(a_re) + h_re), sat_acc((ACC_W+2)'(a_im) + h_im)};
    if (cmd.wr_b) mem[addr_b] <= {sat_acc((ACC_W+2)'(a_re) - h_re), sat_acc((ACC_W+2)'(a_im) - h_im)};
  end

  // operand registers and products
  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      a_re <= rd_q[2*ACC_W-1:ACC_W];
      a_im <= rd_q[ACC_W-1:0];
      w_re <= tw[2*TW_W-1:TW_W];
      w_im <= tw[TW_W-1:0];
    end
    if (cmd.mul) begin
      p_rr <= PW'(b_re) * PW'(w_re);
      p_ii <= PW'(b_im) * PW'(w_im);
      p_ri <= PW'(b_re) * PW'(w_im);
      p_ir <= PW'(b_im) * PW'(w_re);
    end
    if (cmd.emit_rd) begin
      bin_real <= mem[addr_a][2*ACC_W-1:ACC_W];
      bin_imag <= mem[addr_a][ACC_W-1:0];
    end
  end

  // round by 15-bit shift
  always_comb begin
    t_re = (PW+2)'(p_rr) - (PW+2)'(p_ii) + (PW+2)'(16384);
    t_im = (PW+2)'(p_ri) + (PW+2)'(p_ir) + (PW+2)'(16384);
    h_re = (ACC_W+2)'(t_re >>> 15);
    h_im = (ACC_W+2)'(t_im >>> 15);
  end

endmodule

@@ sv/radix2_dit_fft.sv @@
// ----------------------------------------------------------------------------
// Radix-2 DIT FFT
// Collects a frame of real samples, transforms it in place, emits bins.
// ----------------------------------------------------------------------------
// channel | signals                         | direction
// in      | in_valid, in_stall, sample      | request in
// out     | out_valid, out_stall, bin_*     | request out
// cfg     | cfg_valid, cfg_ready, cfg_data  | register write
//
// Load: one sample per cycle. Transform: single-port work store, (N/2)*log2N
// butterflies, each through the RD_A, RD_B, MUL and WR states. Emit: one bin
// per cycle unless stalled, followed by a return to load. Reset clears control;
// store is unset until loaded. Input stalls during transform and emit.
// ----------------------------------------------------------------------------
module radix2_dit_fft import fft_pkg::*; #(
  parameter int LOG2_MAX_POINTS = LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ACC_W-1:0]        bin_real,
  output logic signed [ACC_W-1:0]        bin_imag,
  output logic                           last_bin
);

  logic [CFG_W-1:0]           points_log2;
  logic                       cfg_wr;
  fft_cmd_t                   cmd;
  logic [LOG2_MAX_POINTS-1:0] addr_a, addr_b;
  logic [4:0]                 tw_idx;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) points_log2 <= CFG_W'(6);
    else if (cfg_wr) points_log2 <= cfg_data;
  end

  fft_ctrl #(.LOG2_MAX_POINTS(LOG2_MAX_POINTS)) u_ctrl (
    .clk, .rst, .points_log2, .cfg_wr, .in_valid, .in_stall, .out_stall,
    .out_valid, .out_last(last_bin), .cmd, .addr_a, .addr_b, .tw_idx
  );

  fft_dp #(.LOG2_MAX_POINTS(LOG2_MAX_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk, .cmd, .addr_a, .addr_b, .tw_idx, .sample, .bin_real, .bin_imag
  );

endmodule
